FILE: rtl/blank_frame_detector_defines.svh
// Assertion macros for the blank frame detector.
`ifndef BLANK_FRAME_DETECTOR_DEFINES_SVH
`define BLANK_FRAME_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("blank_frame_detector: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define BFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("blank_frame_detector: next-cycle check failed");

`endif

FILE: rtl/bfd_pkg.sv
`timescale 1ns / 1ps

package bfd_pkg;

    localparam int COUNT_BITS = 23;

    localparam int CHANNELS = 4;

    localparam logic [7:0] ALPHA_FLOOR_RESET = 8'd8;
    localparam logic [7:0] DARK_LEVEL_RESET  = 8'd4;
    localparam logic [7:0] MIN_RANGE_RESET   = 8'd6;
    localparam logic       PROMOTE_RESET     = 1'b0;

    localparam logic [7:0] CHANNEL_FULL = 8'hFF;

    typedef logic [COUNT_BITS-1:0] count_t;

    localparam count_t COUNT_MAX = '1;

    typedef logic [1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_ALPHA_FLOOR = 2'd0;
    localparam cfg_idx_t CFG_DARK_LEVEL  = 2'd1;
    localparam cfg_idx_t CFG_MIN_RANGE   = 2'd2;
    localparam cfg_idx_t CFG_PROMOTE     = 2'd3;

    typedef struct packed {
        logic [7:0] alpha_floor;
        logic [7:0] dark_level;
        logic [7:0] min_range;
        logic       promote_faint_alpha;
    } cfg_t;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        pixel_t px;
        logic   colour_lit;
        logic   visible;
    } pix_class_t;

    typedef struct packed {
        logic useful;
        logic has_range;
        logic has_visible;
        logic has_nonblack;
    } verdict_t;

endpackage

FILE: rtl/bfd_pixel_classify.sv
`timescale 1ns / 1ps

module bfd_pixel_classify (
    input  bfd_pkg::cfg_t       cfg,
    input  bfd_pkg::pixel_t     px_in,
    output bfd_pkg::pix_class_t cls
);
    import bfd_pkg::*;

    logic lit;
    logic faint;

    always_comb
    begin
        lit = (px_in.red > cfg.dark_level) || (px_in.green > cfg.dark_level)
            || (px_in.blue > cfg.dark_level);
        faint = px_in.alpha <= cfg.alpha_floor;

        cls.px = px_in;
        // raise faint alpha when the color is lit and promotion is enabled
        if (cfg.promote_faint_alpha && faint && lit)
        begin
            cls.px.alpha = CHANNEL_FULL;
        end
        cls.colour_lit = lit;
        cls.visible    = (cls.px.alpha > cfg.alpha_floor) || lit;
    end

endmodule

FILE: rtl/bfd_frame_stats.sv
`timescale 1ns / 1ps

module bfd_frame_stats (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                update,
    input  logic                last,
    input  bfd_pkg::pix_class_t cls,
    input  logic [7:0]          min_range,
    output bfd_pkg::verdict_t   verdict
);
    import bfd_pkg::*;

    logic [7:0] min_reg [CHANNELS];
    logic [7:0] max_reg [CHANNELS];
    logic [7:0] min_next [CHANNELS];
    logic [7:0] max_next [CHANNELS];
    logic [7:0] px_ch [CHANNELS];
    logic [8:0] span [CHANNELS];

    count_t pixel_reg;
    count_t visible_reg;
    count_t nonblack_reg;
    count_t pixel_next;
    count_t visible_next;
    count_t nonblack_next;

    logic range_hit;

    always_comb
    begin
        px_ch[0] = cls.px.alpha;
        px_ch[1] = cls.px.red;
        px_ch[2] = cls.px.green;
        px_ch[3] = cls.px.blue;

        range_hit = 1'b0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            min_next[c] = (px_ch[c] < min_reg[c]) ? px_ch[c] : min_reg[c];
            max_next[c] = (px_ch[c] > max_reg[c]) ? px_ch[c] : max_reg[c];
            span[c]     = {1'b0, max_next[c]} - {1'b0, min_next[c]};
            if (!span[c][8] && (span[c][7:0] >= min_range))
            begin
                range_hit = 1'b1;
            end
        end

        pixel_next    = (pixel_reg == COUNT_MAX) ? pixel_reg : pixel_reg + 1'b1;
        visible_next  = visible_reg;
        nonblack_next = nonblack_reg;
        if (cls.visible && (visible_reg != COUNT_MAX))
        begin
            visible_next = visible_reg + 1'b1;
        end
        if (cls.colour_lit && (nonblack_reg != COUNT_MAX))
        begin
            nonblack_next = nonblack_reg + 1'b1;
        end

        verdict.has_range    = range_hit;
        verdict.has_visible  = visible_next > (pixel_next >> 2);
        verdict.has_nonblack = nonblack_next > (pixel_next >> 7);
        verdict.useful       = verdict.has_range && verdict.has_visible
                             && verdict.has_nonblack;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                min_reg[c] <= CHANNEL_FULL;
                max_reg[c] <= '0;
            end
            pixel_reg    <= '0;
            visible_reg  <= '0;
            nonblack_reg <= '0;
        end
        else if (update)
        begin
            if (last)
            begin
                // clear for the next frame
                for (int c = 0; c < CHANNELS; c++)
                begin
                    min_reg[c] <= CHANNEL_FULL;
                    max_reg[c] <= '0;
                end
                pixel_reg    <= '0;
                visible_reg  <= '0;
                nonblack_reg <= '0;
            end
            else
            begin
                for (int c = 0; c < CHANNELS; c++)
                begin
                    min_reg[c] <= min_next[c];
                    max_reg[c] <= max_next[c];
                end
                pixel_reg    <= pixel_next;
                visible_reg  <= visible_next;
                nonblack_reg <= nonblack_next;
            end
        end
    end

endmodule

FILE: rtl/blank_frame_detector.sv
`timescale 1ns / 1ps
`include "blank_frame_detector_defines.svh"

// Blank frame detector: takes one pixel word per cycle (alpha, red, green,
// blue, last_pixel) unless in_stall is high and, after the last pixel of a
// frame, returns one verdict word (useful, has_range, has_visible,
// has_nonblack); all other pixels give no word. Throughput is one pixel per
// clock while not stalled; a pixel is held in the input register, is folded
// into the per-channel min/max and the saturating counters, and on the last
// pixel the verdict is registered in the output register. The block stalls
// its input only when a last pixel is waiting and the previous verdict has
// not yet been taken. Write the configuration registers only between frames.

module blank_frame_detector (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  bfd_pkg::cfg_idx_t         cfg_index,
    input  logic [7:0]                cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                alpha,
    input  logic [7:0]                red,
    input  logic [7:0]                green,
    input  logic [7:0]                blue,
    input  logic                      last_pixel,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      useful,
    output logic                      has_range,
    output logic                      has_visible,
    output logic                      has_nonblack
);
    import bfd_pkg::*;

    cfg_t       cfg_reg;
    pixel_t     pix_reg;
    logic       pix_valid_reg;
    logic       pix_last_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    verdict_t   verdict_reg;
    verdict_t   verdict;
    pix_class_t cls;
    logic       advance;
    logic       load_in;
    logic       load_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alpha_floor         <= ALPHA_FLOOR_RESET;
            cfg_reg.dark_level          <= DARK_LEVEL_RESET;
            cfg_reg.min_range           <= MIN_RANGE_RESET;
            cfg_reg.promote_faint_alpha <= PROMOTE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_ALPHA_FLOOR: cfg_reg.alpha_floor         <= cfg_data;
                CFG_DARK_LEVEL:  cfg_reg.dark_level          <= cfg_data;
                CFG_MIN_RANGE:   cfg_reg.min_range           <= cfg_data;
                CFG_PROMOTE:     cfg_reg.promote_faint_alpha <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // hold a last pixel while the previous verdict waits
    assign advance  = pix_valid_reg && (!pix_last_reg || !out_valid_reg || !out_stall);
    assign in_stall = pix_valid_reg && !advance;
    assign load_in  = in_valid && !in_stall;
    assign load_out = advance && pix_last_reg;

    always_comb
    begin
        out_valid_next = (out_valid_reg && out_stall) || load_out;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pix_valid_reg <= load_in || (pix_valid_reg && !advance);
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            pix_reg.alpha <= alpha;
            pix_reg.red   <= red;
            pix_reg.green <= green;
            pix_reg.blue  <= blue;
            pix_last_reg  <= last_pixel;
        end
        if (load_out)
        begin
            verdict_reg <= verdict;
        end
    end

    bfd_pixel_classify u_classify (
        .cfg   (cfg_reg),
        .px_in (pix_reg),
        .cls   (cls)
    );

    bfd_frame_stats u_stats (
        .clk       (clk),
        .rst_n     (rst_n),
        .update    (advance),
        .last      (pix_last_reg),
        .cls       (cls),
        .min_range (cfg_reg.min_range),
        .verdict   (verdict)
    );

    assign out_valid    = out_valid_reg;
    assign useful       = verdict_reg.useful;
    assign has_range    = verdict_reg.has_range;
    assign has_visible  = verdict_reg.has_visible;
    assign has_nonblack = verdict_reg.has_nonblack;

    `BFD_ASSERT_NOW(a_stall_only_on_last, clk, rst_n, in_stall, pix_valid_reg && pix_last_reg && out_valid_reg && out_stall)
    `BFD_ASSERT_NOW(a_useful_is_and, clk, rst_n, out_valid_reg, useful == (has_range && has_visible && has_nonblack))
    `BFD_ASSERT_NEXT(a_verdict_follows_last, clk, rst_n, load_out, out_valid_reg)

endmodule
